// ----- design/sspad_pkg.sv -----
`timescale 1ns / 1ps

package sspad_pkg;

    // Default widths of the duty registers and the tick counter
    localparam int DUTY_WIDTH_DEF = 16;
    localparam int TICK_WIDTH_DEF = 16;

    // Port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int OUT_DUTY_W = 16;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELEASE_LEVEL  = 3'd0,
        CFG_DUAL_DRIVE     = 3'd1,
        CFG_MAX_DUTY       = 3'd2,
        CFG_HOLD_DUTY      = 3'd3,
        CFG_RAMP_INCREMENT = 3'd4,
        CFG_STEP_PAUSE     = 3'd5,
        CFG_SETTLE_TICKS   = 3'd6,
        CFG_PWM_BITS       = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic        RST_RELEASE_LEVEL  = 1'b0;
    localparam logic        RST_DUAL_DRIVE     = 1'b0;
    localparam logic [15:0] RST_MAX_DUTY       = 16'd255;
    localparam logic [15:0] RST_HOLD_DUTY      = 16'd0;
    localparam logic [23:0] RST_RAMP_INCREMENT = 24'd256;
    localparam logic [15:0] RST_STEP_PAUSE     = 16'd1;
    localparam logic [15:0] RST_SETTLE_TICKS   = 16'd0;
    localparam logic [4:0]  RST_PWM_BITS       = 5'd8;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BRAKE  = 2'd1,
        PH_RAMP   = 2'd2,
        PH_SETTLE = 2'd3
    } t_phase;

    typedef struct packed {
        logic        release_level;
        logic        dual_drive;
        logic [15:0] max_duty;
        logic [15:0] hold_duty;
        logic [23:0] ramp_increment;
        logic [15:0] step_pause_ticks;
        logic [15:0] settle_ticks;
        logic [4:0]  pwm_bits;
    } t_cfg;

    // First member is the top bit: drive_a_duty lands in the lowest bits
    typedef struct packed {
        logic                  settled_position;
        t_phase                phase_now;
        logic [OUT_DUTY_W-1:0] drive_b_duty;
        logic [OUT_DUTY_W-1:0] drive_a_duty;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// ----- design/soft_start_pwm_actuator_driver_top.sv -----
`timescale 1ns / 1ps

// Soft-start PWM driver for one solenoid or one H-bridge.
// Input stream (s_axis): one beat per millisecond tick or position command.
//   tuser is the beat kind (0 tick, 1 command), tdata[0] the commanded position.
// Output stream (m_axis): exactly one beat per input beat, carrying both duties,
//   the current phase (idle/hold, brake, ramp, settle) and the settled position.
// Config port (cfg): register index plus data, always ready; write only while
//   no beat is in flight.
// A result is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle while the output is not stalled; the whole
//   state update (one 25-bit add, one clamp compare and one counter decrement)
//   sits between the state registers and the output register.
// Stall: the output register holds its beat while m_axis_tready is low, and
//   s_axis_tready drops only then; it stays high whenever the held beat leaves.
// Reset (i_rst_n low, synchronous): registers go to their defaults, the
//   sequence goes idle with position and target one, duties zero, no output.

module soft_start_pwm_actuator_driver_top #(
    parameter int DUTY_WIDTH = sspad_pkg::DUTY_WIDTH_DEF,
    parameter int TICK_WIDTH = sspad_pkg::TICK_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sspad_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sspad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sspad_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [0] command_value
    input  logic                              s_axis_tuser,  // [0] mode
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] drive_a_duty, [31:16] drive_b_duty, [33:32] phase_now,
    // [34] settled_position, [39:35] zero
    output logic [sspad_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    sspad_pkg::t_cfg    w_cfg;
    sspad_pkg::t_result w_result;
    logic               w_accept;

    // Beat taken from the input stream
    assign w_accept = s_axis_tvalid && s_axis_tready;

    sspad_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Sequencer state and the next-state logic for one beat
    sspad_core #(
        .DUTY_WIDTH (DUTY_WIDTH),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_mode          (s_axis_tuser),
        .i_command_value (s_axis_tdata[0]),
        .i_cfg           (w_cfg),
        .o_result        (w_result)
    );

    // Result register; its free slot sets input ready
    sspad_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_result (w_result),
        .o_ready  (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .i_taken  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule

// ----- design/sspad_cfg.sv -----
`timescale 1ns / 1ps

module sspad_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sspad_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sspad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sspad_pkg::t_cfg                   o_cfg
);

    sspad_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.release_level    <= sspad_pkg::RST_RELEASE_LEVEL;
            r_cfg.dual_drive       <= sspad_pkg::RST_DUAL_DRIVE;
            r_cfg.max_duty         <= sspad_pkg::RST_MAX_DUTY;
            r_cfg.hold_duty        <= sspad_pkg::RST_HOLD_DUTY;
            r_cfg.ramp_increment   <= sspad_pkg::RST_RAMP_INCREMENT;
            r_cfg.step_pause_ticks <= sspad_pkg::RST_STEP_PAUSE;
            r_cfg.settle_ticks     <= sspad_pkg::RST_SETTLE_TICKS;
            r_cfg.pwm_bits         <= sspad_pkg::RST_PWM_BITS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sspad_pkg::CFG_RELEASE_LEVEL:  r_cfg.release_level    <= i_cfg_data[0];
                sspad_pkg::CFG_DUAL_DRIVE:     r_cfg.dual_drive       <= i_cfg_data[0];
                sspad_pkg::CFG_MAX_DUTY:       r_cfg.max_duty         <= i_cfg_data[15:0];
                sspad_pkg::CFG_HOLD_DUTY:      r_cfg.hold_duty        <= i_cfg_data[15:0];
                sspad_pkg::CFG_RAMP_INCREMENT: r_cfg.ramp_increment   <= i_cfg_data[23:0];
                sspad_pkg::CFG_STEP_PAUSE:     r_cfg.step_pause_ticks <= i_cfg_data[15:0];
                sspad_pkg::CFG_SETTLE_TICKS:   r_cfg.settle_ticks     <= i_cfg_data[15:0];
                sspad_pkg::CFG_PWM_BITS:       r_cfg.pwm_bits         <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- design/sspad_core.sv -----
`timescale 1ns / 1ps

module sspad_core #(
    parameter int DUTY_WIDTH = sspad_pkg::DUTY_WIDTH_DEF,
    parameter int TICK_WIDTH = sspad_pkg::TICK_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_mode,
    input  logic               i_command_value,
    input  sspad_pkg::t_cfg    i_cfg,
    output sspad_pkg::t_result o_result
);

    logic                  r_pos, n_pos;
    logic                  r_tgt, n_tgt;
    sspad_pkg::t_phase     r_phase, n_phase;
    logic [TICK_WIDTH-1:0] r_wait, n_wait;
    logic [23:0]           r_ramp, n_ramp;
    logic [DUTY_WIDTH-1:0] r_da, n_da;
    logic [DUTY_WIDTH-1:0] r_db, n_db;

    // Zero-length waits last one tick
    function automatic logic [TICK_WIDTH-1:0] load_wait(input logic [15:0] w);
        logic [TICK_WIDTH-1:0] t;
        t = TICK_WIDTH'(w);
        return (t == '0) ? TICK_WIDTH'(1) : t;
    endfunction

    always_comb begin
        logic                  do_start, do_adv, ramp_go, begin_r, t_eff;
        logic [TICK_WIDTH-1:0] wait_dec;
        logic [23:0]           step, top, level;
        logic [24:0]           sum;
        logic [DUTY_WIDTH-1:0] act, brake_lvl;

        n_pos   = r_pos;
        n_tgt   = r_tgt;
        n_phase = r_phase;
        n_wait  = r_wait;
        n_ramp  = r_ramp;
        n_da    = r_da;
        n_db    = r_db;

        do_start = 1'b0;
        do_adv   = 1'b0;
        ramp_go  = 1'b0;
        begin_r  = 1'b0;
        wait_dec = r_wait - TICK_WIDTH'(1);

        // Decode the beat: tick or command
        if (!i_mode) begin
            if (r_phase != sspad_pkg::PH_IDLE) begin
                n_wait = wait_dec;
                do_adv = (wait_dec == '0);
            end
        end else if (r_phase == sspad_pkg::PH_IDLE) begin
            do_start = (i_command_value != r_pos);
        end else if (i_command_value != r_tgt) begin
            do_start = 1'b1;
        end else begin
            do_adv = 1'b1;
        end

        t_eff = do_start ? i_command_value : r_tgt;

        if (int'(i_cfg.pwm_bits) >= DUTY_WIDTH) begin
            brake_lvl = '1;
        end else begin
            brake_lvl = ~({DUTY_WIDTH{1'b1}} << i_cfg.pwm_bits);
        end

        if (do_start) begin
            n_tgt = i_command_value;
            if (i_cfg.dual_drive) begin
                n_da    = brake_lvl;
                n_db    = brake_lvl;
                n_phase = sspad_pkg::PH_BRAKE;
                n_wait  = load_wait({1'b0, i_cfg.settle_ticks[15:1]});
            end else if (i_command_value == i_cfg.release_level) begin
                n_da    = '0;
                n_pos   = i_command_value;
                n_phase = sspad_pkg::PH_IDLE;
            end else begin
                ramp_go = 1'b1;
                begin_r = 1'b1;
            end
        end else if (do_adv) begin
            case (r_phase)
                sspad_pkg::PH_BRAKE: begin
                    ramp_go = 1'b1;
                    begin_r = 1'b1;
                end
                sspad_pkg::PH_RAMP: begin
                    ramp_go = 1'b1;
                end
                sspad_pkg::PH_SETTLE: begin
                    if (i_cfg.dual_drive && !r_tgt) begin
                        n_db = DUTY_WIDTH'(i_cfg.hold_duty);
                    end else begin
                        n_da = DUTY_WIDTH'(i_cfg.hold_duty);
                    end
                    n_phase = sspad_pkg::PH_IDLE;
                end
                default: ;
            endcase
        end

        // Ramp step: first level is one step, later ones clamp at max_duty
        step  = (i_cfg.ramp_increment == '0) ? 24'd1 : i_cfg.ramp_increment;
        top   = {i_cfg.max_duty, 8'h00};
        sum   = {1'b0, r_ramp} + {1'b0, step};
        if (begin_r) begin
            level = step;
        end else if (sum > {1'b0, top}) begin
            level = top;
        end else begin
            level = sum[23:0];
        end
        act = DUTY_WIDTH'(level[23:8]);

        if (ramp_go) begin
            n_ramp = level;
            if (begin_r && i_cfg.dual_drive) begin
                if (t_eff) begin
                    n_db = '0;
                end else begin
                    n_da = '0;
                end
            end
            if (i_cfg.dual_drive && !t_eff) begin
                n_db = act;
            end else begin
                n_da = act;
            end
            if (level < top) begin
                n_phase = sspad_pkg::PH_RAMP;
                n_wait  = load_wait(i_cfg.step_pause_ticks);
            end else begin
                n_pos   = t_eff;
                n_phase = sspad_pkg::PH_SETTLE;
                n_wait  = load_wait(i_cfg.settle_ticks);
            end
        end
    end

    always_comb begin
        o_result.drive_a_duty     = sspad_pkg::OUT_DUTY_W'(n_da);
        o_result.drive_b_duty     = i_cfg.dual_drive ? sspad_pkg::OUT_DUTY_W'(n_db) : '0;
        o_result.phase_now        = n_phase;
        o_result.settled_position = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 1'b1;
            r_tgt   <= 1'b1;
            r_phase <= sspad_pkg::PH_IDLE;
            r_wait  <= '0;
            r_ramp  <= '0;
            r_da    <= '0;
            r_db    <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_tgt   <= n_tgt;
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_ramp  <= n_ramp;
            r_da    <= n_da;
            r_db    <= n_db;
        end
    end

endmodule

// ----- design/sspad_out.sv -----
`timescale 1ns / 1ps

module sspad_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  sspad_pkg::t_result               i_result,
    output logic                             o_ready,
    output logic                             o_valid,
    input  logic                             i_taken,
    output logic [sspad_pkg::M_TDATA_W-1:0]  o_data
);

    logic               r_valid;
    sspad_pkg::t_result r_result;

    // Room for a new beat when empty or when the held beat leaves now
    assign o_ready = !r_valid || i_taken;
    assign o_valid = r_valid;
    assign o_data  = {{(sspad_pkg::M_TDATA_W - sspad_pkg::RESULT_W){1'b0}}, r_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- design/sspad_chk.sv -----
`timescale 1ns / 1ps

module sspad_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [sspad_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [sspad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [sspad_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sspad_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    // A stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // Input is refused only while the output register is full and stalled
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused without an output stall");

    // A result appears only after an input beat was taken
    a_no_invented_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result beat without an input beat");

    // Back to back: a beat taken while the output drains gives a fresh beat
    a_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

endmodule

bind soft_start_pwm_actuator_driver_top sspad_chk u_sspad_chk (.*);

// ----- dv/soft_start_pwm_actuator_driver_top_tb.sv -----
`timescale 1ns / 1ps

module soft_start_pwm_actuator_driver_top_tb;

    localparam int   CLK_HALF     = 10;
    localparam int   RESET_CYCLES = 7;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   QUIET_CYCLES = 4;     // result lags its beat by the output register
    localparam int   MAX_REPORTS  = 60;
    localparam int   RANDOM_ROUNDS = 14;
    localparam int   BEATS_PER_ROUND = 125;
    localparam logic BEAT_TICK    = 1'b0;
    localparam logic BEAT_COMMAND = 1'b1;

    logic                                  i_clk         = 1'b0;
    logic                                  i_rst_n       = 1'b0;
    logic                                  i_cfg_valid   = 1'b0;
    logic                                  o_cfg_ready;
    logic [sspad_pkg::CFG_IDX_W-1:0]       i_cfg_index   = '0;
    logic [sspad_pkg::CFG_DATA_W-1:0]      i_cfg_data    = '0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [sspad_pkg::S_TDATA_W-1:0]       s_axis_tdata  = '0;
    logic                                  s_axis_tuser  = 1'b0;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [sspad_pkg::M_TDATA_W-1:0]       m_axis_tdata;

    soft_start_pwm_actuator_driver_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Driver state mirror: register shadow plus sequence state
    sspad_pkg::t_cfg   regs;
    logic              position_q;
    logic              target_q;
    sspad_pkg::t_phase phase_q;
    logic [15:0]       wait_left;
    logic [31:0]       ramp_q;            // Q16.8 ramp level
    logic [15:0]       duty_a_q;
    logic [15:0]       duty_b_q;

    sspad_pkg::t_result pending_results[$];
    int          error_count   = 0;
    int          results_taken = 0;
    int          stall_mark    = 0;
    int          hold_left     = 0;
    int          cycle_count   = 0;
    int          sent_beats    = 0;  // input beats taken so far
    bit          no_gaps       = 1'b0;

    // ---------------------------------------------------------------
    // Sequence prediction
    // ---------------------------------------------------------------
    function automatic void load_wait(input logic [15:0] w);
        wait_left = (w == 16'd0) ? 16'd1 : w;   // zero-length wait lasts one tick
    endfunction

    function automatic logic [31:0] ramp_step();
        return (regs.ramp_increment == 24'd0) ? 32'd1 : 32'(regs.ramp_increment);
    endfunction

    function automatic void drive_active(input logic [15:0] d);
        if (regs.dual_drive && !target_q) begin
            duty_b_q = d;
        end else begin
            duty_a_q = d;
        end
    endfunction

    function automatic void close_or_continue_ramp();
        if (ramp_q < {8'd0, regs.max_duty, 8'd0}) begin
            phase_q = sspad_pkg::PH_RAMP;
            load_wait(regs.step_pause_ticks);
        end else begin
            position_q = target_q;
            phase_q    = sspad_pkg::PH_SETTLE;
            load_wait(regs.settle_ticks);
        end
    endfunction

    function automatic void start_ramp();
        ramp_q = ramp_step();
        if (regs.dual_drive) begin
            if (target_q) begin
                duty_b_q = '0;
            end else begin
                duty_a_q = '0;
            end
        end
        drive_active(ramp_q[23:8]);
        close_or_continue_ramp();
    endfunction

    function automatic void launch_sequence(input logic t);
        logic [15:0] brake;
        target_q = t;
        if (!regs.dual_drive) begin
            if (t == regs.release_level) begin
                duty_a_q   = '0;
                position_q = t;
                phase_q    = sspad_pkg::PH_IDLE;
            end else begin
                start_ramp();
            end
        end else begin
            // brake level saturates at full duty scale
            brake = (regs.pwm_bits >= 5'd16) ? 16'hFFFF
                                             : 16'((32'd1 << regs.pwm_bits) - 32'd1);
            duty_a_q = brake;
            duty_b_q = brake;
            phase_q  = sspad_pkg::PH_BRAKE;
            load_wait(regs.settle_ticks >> 1);
        end
    endfunction

    function automatic void advance_phase();
        logic [31:0] top;
        logic [31:0] nxt;
        case (phase_q)
            sspad_pkg::PH_BRAKE: begin
                start_ramp();
            end
            sspad_pkg::PH_RAMP: begin
                top    = {8'd0, regs.max_duty, 8'd0};
                nxt    = ramp_q + ramp_step();
                ramp_q = (nxt > top) ? top : nxt;
                drive_active(ramp_q[23:8]);
                close_or_continue_ramp();
            end
            sspad_pkg::PH_SETTLE: begin
                drive_active(regs.hold_duty);
                phase_q = sspad_pkg::PH_IDLE;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic sspad_pkg::t_result predict_beat(input logic kind, input logic value);
        sspad_pkg::t_result r;
        if (kind == BEAT_TICK) begin
            if (phase_q != sspad_pkg::PH_IDLE) begin
                wait_left = wait_left - 16'd1;
                if (wait_left == 16'd0) begin
                    advance_phase();
                end
            end
        end else if (phase_q == sspad_pkg::PH_IDLE) begin
            if (value != position_q) begin
                launch_sequence(value);
            end
        end else if (value != target_q) begin
            launch_sequence(value);
        end else begin
            advance_phase();    // matching command cuts the wait short
        end
        r.drive_a_duty     = duty_a_q;
        r.drive_b_duty     = regs.dual_drive ? duty_b_q : '0;
        r.phase_now        = phase_q;
        r.settled_position = position_q;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus side
    // ---------------------------------------------------------------
    function automatic int draw_gap();
        return no_gaps ? 0 : int'($urandom_range(0, 5));
    endfunction

    task automatic apply_reset();
        regs.release_level    = sspad_pkg::RST_RELEASE_LEVEL;
        regs.dual_drive       = sspad_pkg::RST_DUAL_DRIVE;
        regs.max_duty         = sspad_pkg::RST_MAX_DUTY;
        regs.hold_duty        = sspad_pkg::RST_HOLD_DUTY;
        regs.ramp_increment   = sspad_pkg::RST_RAMP_INCREMENT;
        regs.step_pause_ticks = sspad_pkg::RST_STEP_PAUSE;
        regs.settle_ticks     = sspad_pkg::RST_SETTLE_TICKS;
        regs.pwm_bits         = sspad_pkg::RST_PWM_BITS;
        position_q = 1'b1;
        target_q   = 1'b1;
        phase_q    = sspad_pkg::PH_IDLE;
        wait_left  = '0;
        ramp_q     = '0;
        duty_a_q   = '0;
        duty_b_q   = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    // One input beat; s_axis_tvalid stays high when the next beat follows at once
    task automatic send_beat(input logic kind, input logic value);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = sspad_pkg::S_TDATA_W'(value);
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pending_results.push_back(predict_beat(kind, value));
        sent_beats++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_beat(BEAT_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_until_quiet();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input sspad_pkg::t_cfg_idx idx,
                             input logic [sspad_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            sspad_pkg::CFG_RELEASE_LEVEL:  regs.release_level    = value[0];
            sspad_pkg::CFG_DUAL_DRIVE:     regs.dual_drive       = value[0];
            sspad_pkg::CFG_MAX_DUTY:       regs.max_duty         = value[15:0];
            sspad_pkg::CFG_HOLD_DUTY:      regs.hold_duty        = value[15:0];
            sspad_pkg::CFG_RAMP_INCREMENT: regs.ramp_increment   = value[23:0];
            sspad_pkg::CFG_STEP_PAUSE:     regs.step_pause_ticks = value[15:0];
            sspad_pkg::CFG_SETTLE_TICKS:   regs.settle_ticks     = value[15:0];
            sspad_pkg::CFG_PWM_BITS:       regs.pwm_bits         = value[4:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic program_registers(input sspad_pkg::t_cfg c);
        write_reg(sspad_pkg::CFG_RELEASE_LEVEL,
                  sspad_pkg::CFG_DATA_W'(c.release_level));
        write_reg(sspad_pkg::CFG_DUAL_DRIVE, sspad_pkg::CFG_DATA_W'(c.dual_drive));
        write_reg(sspad_pkg::CFG_MAX_DUTY, sspad_pkg::CFG_DATA_W'(c.max_duty));
        write_reg(sspad_pkg::CFG_HOLD_DUTY, sspad_pkg::CFG_DATA_W'(c.hold_duty));
        write_reg(sspad_pkg::CFG_RAMP_INCREMENT,
                  sspad_pkg::CFG_DATA_W'(c.ramp_increment));
        write_reg(sspad_pkg::CFG_STEP_PAUSE,
                  sspad_pkg::CFG_DATA_W'(c.step_pause_ticks));
        write_reg(sspad_pkg::CFG_SETTLE_TICKS, sspad_pkg::CFG_DATA_W'(c.settle_ticks));
        write_reg(sspad_pkg::CFG_PWM_BITS, sspad_pkg::CFG_DATA_W'(c.pwm_bits));
    endtask

    // sel 1 forces the low extreme, 2 the high one; otherwise mostly typical values
    function automatic logic [23:0] pick_value(input int sel, input int unsigned typ_lo,
                                               input int unsigned typ_hi,
                                               input int unsigned ext_lo,
                                               input int unsigned ext_hi);
        int unsigned roll;
        roll = $urandom_range(0, 5);
        if (sel == 1 || (sel == 0 && roll == 0)) begin
            return 24'(ext_lo);
        end else if (sel == 2 || (sel == 0 && roll == 1)) begin
            return 24'(ext_hi);
        end
        return 24'($urandom_range(typ_lo, typ_hi));
    endfunction

    function automatic sspad_pkg::t_cfg random_settings(input int sel);
        sspad_pkg::t_cfg c;
        c.release_level    = 1'($urandom_range(0, 1));
        c.dual_drive       = 1'($urandom_range(0, 1));
        c.max_duty         = 16'(pick_value(sel, 0, 12, 0, 65535));
        c.hold_duty        = 16'(pick_value(sel, 0, 65535, 0, 65535));
        c.ramp_increment   = pick_value(sel, 32, 1024, 0, 24'hFFFFFF);
        c.step_pause_ticks = 16'(pick_value(sel, 0, 3, 0, 65535));
        c.settle_ticks     = 16'(pick_value(sel, 0, 7, 0, 65535));
        c.pwm_bits         = 5'(pick_value(sel, 1, 16, 0, 31));
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset register values: idle tick, ignored command, release, ramp start,
    // one ramp step by tick, one cut short by command, restart into release
    task automatic test_default_registers();
        send_beat(BEAT_TICK, 1'b1);
        send_beat(BEAT_COMMAND, 1'b1);
        send_beat(BEAT_COMMAND, 1'b0);
        send_beat(BEAT_COMMAND, 1'b1);
        send_beat(BEAT_TICK, 1'b0);
        send_beat(BEAT_COMMAND, 1'b1);
        send_beat(BEAT_COMMAND, 1'b0);
        wait_until_quiet();
    endtask

    // Single solenoid, release level one, full-scale hold after a short ramp
    task automatic test_single_ramp();
        write_reg(sspad_pkg::CFG_RELEASE_LEVEL, 24'd1);
        write_reg(sspad_pkg::CFG_MAX_DUTY, 24'd3);
        write_reg(sspad_pkg::CFG_HOLD_DUTY, 24'hFFFF);
        write_reg(sspad_pkg::CFG_RAMP_INCREMENT, 24'h000100);
        write_reg(sspad_pkg::CFG_STEP_PAUSE, 24'd0);
        send_beat(BEAT_COMMAND, 1'b1);
        send_beat(BEAT_COMMAND, 1'b0);
        send_ticks(3);
        wait_until_quiet();
    endtask

    // Bridge: brake, fractional steps, early end, restart, then a switch to
    // single mode while the ramp is still running
    task automatic test_bridge_sequence();
        write_reg(sspad_pkg::CFG_DUAL_DRIVE, 24'd1);
        write_reg(sspad_pkg::CFG_PWM_BITS, 24'd16);
        write_reg(sspad_pkg::CFG_SETTLE_TICKS, 24'd3);
        write_reg(sspad_pkg::CFG_MAX_DUTY, 24'd2);
        write_reg(sspad_pkg::CFG_RAMP_INCREMENT, 24'h000080);
        write_reg(sspad_pkg::CFG_STEP_PAUSE, 24'd2);
        write_reg(sspad_pkg::CFG_HOLD_DUTY, 24'd5);
        send_beat(BEAT_COMMAND, 1'b1);
        send_ticks(2);
        send_beat(BEAT_COMMAND, 1'b1);
        send_beat(BEAT_COMMAND, 1'b0);
        send_beat(BEAT_COMMAND, 1'b0);
        wait_until_quiet();
        write_reg(sspad_pkg::CFG_DUAL_DRIVE, 24'd0);
        send_ticks(2);
        repeat (3) send_beat(BEAT_COMMAND, 1'b0);
        wait_until_quiet();
    endtask

    // Zero brake level, zero increment, zero max, then a first step that
    // already overshoots max with the brake level saturated
    task automatic test_ramp_edges();
        write_reg(sspad_pkg::CFG_DUAL_DRIVE, 24'd1);
        write_reg(sspad_pkg::CFG_PWM_BITS, 24'd0);
        write_reg(sspad_pkg::CFG_SETTLE_TICKS, 24'd0);
        write_reg(sspad_pkg::CFG_RAMP_INCREMENT, 24'd0);
        write_reg(sspad_pkg::CFG_MAX_DUTY, 24'd0);
        send_beat(BEAT_COMMAND, 1'b1);
        send_beat(BEAT_TICK, 1'b1);
        wait_until_quiet();
        write_reg(sspad_pkg::CFG_PWM_BITS, 24'd31);
        write_reg(sspad_pkg::CFG_RAMP_INCREMENT, 24'hFFFFFF);
        write_reg(sspad_pkg::CFG_MAX_DUTY, 24'd100);
        send_beat(BEAT_COMMAND, 1'b0);
        send_beat(BEAT_COMMAND, 1'b0);
        send_beat(BEAT_TICK, 1'b0);
        wait_until_quiet();
    endtask

    // Rounds of fresh register settings; round 2 takes every low extreme and
    // round 3 every high one. Most traffic is a command followed by a run of
    // ticks, the rest short bursts of random beats.
    task automatic test_random_traffic();
        sspad_pkg::t_cfg c;
        int   start;
        int   run;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            wait_until_quiet();
            c = random_settings((round == 2) ? 1 : (round == 3) ? 2 : 0);
            program_registers(c);
            no_gaps = (round % 4 == 1);
            start   = sent_beats;
            while (sent_beats - start < BEATS_PER_ROUND) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_beat(BEAT_COMMAND, 1'($urandom_range(0, 1)));
                    run = $urandom_range(1, 30);
                    repeat (run) begin
                        if ($urandom_range(0, 15) == 0) begin
                            send_beat(BEAT_COMMAND, 1'($urandom_range(0, 1)));
                        end else begin
                            send_ticks(1);
                        end
                    end
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    end
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        sspad_pkg::t_result got;
        sspad_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[sspad_pkg::RESULT_W-1:0];
            results_taken++;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t ns: result beat with none expected, expected nothing, got %h",
                             $time, m_axis_tdata);
                end
            end else begin
                want = pending_results.pop_front();
                check_field("drive_a_duty", 32'(want.drive_a_duty), 32'(got.drive_a_duty));
                check_field("drive_b_duty", 32'(want.drive_b_duty), 32'(got.drive_b_duty));
                check_field("phase_now", 32'(want.phase_now), 32'(got.phase_now));
                check_field("settled_position", 32'(want.settled_position),
                            32'(got.settled_position));
            end
            check_field("tdata pad", 0,
                        32'(m_axis_tdata[sspad_pkg::M_TDATA_W-1:sspad_pkg::RESULT_W]));
        end
    end

    // Output backpressure: a fresh stall length after every result beat
    always @(negedge i_clk) begin
        if (results_taken != stall_mark) begin
            stall_mark = results_taken;
            hold_left  = draw_gap();
        end
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        apply_reset();
        test_default_registers();
        test_single_ramp();
        test_bridge_sequence();
        test_ramp_edges();
        test_random_traffic();
        wait_until_quiet();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/sspad_pkg.sv
design/sspad_cfg.sv
design/sspad_core.sv
design/sspad_out.sv
design/soft_start_pwm_actuator_driver_top.sv
design/sspad_chk.sv
dv/soft_start_pwm_actuator_driver_top_tb.sv
